/* sv/mqtt_fixed_header_parser_core_macros.svh */
// Assertion macros for the MQTT fixed-header parser checker.
// Each use expands to one labeled concurrent assertion clocked on rising edges.
`ifndef MQTT_FIXED_HEADER_PARSER_CORE_MACROS_SVH
`define MQTT_FIXED_HEADER_PARSER_CORE_MACROS_SVH

// Check a property outside reset.
`define MFHP_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Check a property in every cycle, reset included.
`define MFHP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/mfhp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfhp_pkg
// Types and codes shared by the MQTT fixed-header parser modules.
// ----------------------------------------------------------------------------
package mfhp_pkg;

    // Parse phase after each byte
    typedef enum logic [2:0] {
        PH_CTRL = 3'd0,
        PH_LEN  = 3'd1,
        PH_BODY = 3'd2,
        PH_DONE = 3'd3,
        PH_ERR  = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_CTRL    = 2'd1,
        ERR_LEN     = 2'd2,
        ERR_CONNECT = 2'd3
    } err_t;

    // Protocol name seen in the CONNECT header
    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_V4   = 2'd1,
        KIND_V3   = 2'd2
    } kind_t;

    // Control packet types with special rules
    localparam logic [3:0] TYPE_RESERVED_LO = 4'd0;
    localparam logic [3:0] TYPE_CONNECT     = 4'd1;
    localparam logic [3:0] TYPE_PUBLISH     = 4'd3;
    localparam logic [3:0] TYPE_PUBREL      = 4'd6;
    localparam logic [3:0] TYPE_SUBSCRIBE   = 4'd8;
    localparam logic [3:0] TYPE_UNSUBSCRIBE = 4'd10;
    localparam logic [3:0] TYPE_RESERVED_HI = 4'd15;

    localparam logic [3:0] FLAGS_REQUIRED   = 4'h2;
    localparam logic [3:0] FLAGS_ZERO       = 4'h0;

    // CONNECT header constants
    localparam logic [7:0] NAME_LEN_V4      = 8'h04;
    localparam logic [7:0] NAME_LEN_V3      = 8'h06;
    localparam logic [7:0] LEVEL_V4         = 8'h04;
    localparam logic [7:0] LEVEL_V3         = 8'h03;
    localparam logic [3:0] HDR_IDX_MAX      = 4'd15;

    // One input beat
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       session_connecting;
        logic       restart;
    } item_t;

    // Parser state carried between beats
    typedef struct packed {
        phase_t      phase;
        logic [3:0]  ptype;
        logic [3:0]  flags;
        logic [27:0] len_accum;
        logic [2:0]  len_cnt;
        logic [27:0] bytes_left;
        logic [3:0]  hdr_idx;
        kind_t       name_kind;
        logic [7:0]  level;
        logic [7:0]  cflags;
        logic [15:0] keep_alive;
        err_t        err;
    } state_t;

    // One result beat
    typedef struct packed {
        err_t        error_code;
        logic        packet_done;
        phase_t      parse_phase;
        logic [3:0]  packet_type;
        logic [3:0]  packet_flags;
        logic [27:0] remaining_length;
        logic [7:0]  protocol_level;
        logic [7:0]  connect_flag_bits;
        logic [15:0] keep_alive;
        logic [7:0]  body_byte;
        logic        body_valid;
    } result_t;

    // Expected protocol name character at position k of the name
    function automatic logic [7:0] name_char(input kind_t kind, input logic [3:0] k);
        logic [7:0] c;
        c = 8'h00;
        unique case (kind)
            KIND_V4: begin
                unique case (k[1:0])
                    2'd0: c = 8'h4D;
                    2'd1: c = 8'h51;
                    2'd2: c = 8'h54;
                    2'd3: c = 8'h54;
                endcase
            end
            KIND_V3: begin
                unique case (k)
                    4'd0:    c = 8'h4D;
                    4'd1:    c = 8'h51;
                    4'd2:    c = 8'h49;
                    4'd3:    c = 8'h73;
                    4'd4:    c = 8'h64;
                    4'd5:    c = 8'h70;
                    default: c = 8'h00;
                endcase
            end
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

/* sv/mqtt_fixed_header_parser_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mqtt_fixed_header_parser_core
// MQTT fixed-header parser with remaining-length decode and CONNECT check.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one stream byte per beat with session_connecting and restart.
//   m_ channel: exactly one result beat per input beat, in order.
//   A beat accepted into the input register passes through the parse step
//   into the result register, which drives m_valid and the result ports.
//   Throughput: one byte per cycle unless a stall on m_ready fills both
//   registers; combinational update logic feeds the parser state register.
//   A result waiting on m_ready does not stop intake: the input register
//   takes one more beat, and s_ready drops only while both registers are
//   full and m_ready is low.
//   Reset (aresetn low, synchronous) empties both registers and returns the
//   parser to expect a control byte with all captured values zero.
//   Errors are held and repeated until a beat arrives with restart set.
//   MAX_LENGTH_BYTES (1 to 4) limits the remaining-length bytes accepted.
// ----------------------------------------------------------------------------
module mqtt_fixed_header_parser_core #(
    parameter int MAX_LENGTH_BYTES = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,
    input  wire logic        s_session_connecting,
    input  wire logic        s_restart,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_error_code,
    output logic             m_packet_done,
    output logic [2:0]       m_parse_phase,
    output logic [3:0]       m_packet_type,
    output logic [3:0]       m_packet_flags,
    output logic [27:0]      m_remaining_length,
    output logic [7:0]       m_protocol_level,
    output logic [7:0]       m_connect_flag_bits,
    output logic [15:0]      m_keep_alive,
    output logic [7:0]       m_body_byte,
    output logic             m_body_valid
);
    import mfhp_pkg::*;

    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    out_free;
    logic    advance;
    state_t  state_reg;
    state_t  state_next;
    result_t step_result;
    result_t result_out;

    assign s_item.rx_byte            = s_rx_byte;
    assign s_item.session_connecting = s_session_connecting;
    assign s_item.restart            = s_restart;

    // Move the held beat into the result register when there is room
    assign advance = item_valid && out_free;

    mfhp_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    mfhp_step #(
        .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
    ) u_step (
        .state_i    (state_reg),
        .item       (item),
        .state_next (state_next),
        .result     (step_result)
    );

    // Parser state register, updated once per byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    mfhp_out_stage u_out_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (item_valid),
        .result_in  (step_result),
        .out_free   (out_free),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .result_out (result_out)
    );

    // Drive the result ports
    assign m_error_code        = result_out.error_code;
    assign m_packet_done       = result_out.packet_done;
    assign m_parse_phase       = result_out.parse_phase;
    assign m_packet_type       = result_out.packet_type;
    assign m_packet_flags      = result_out.packet_flags;
    assign m_remaining_length  = result_out.remaining_length;
    assign m_protocol_level    = result_out.protocol_level;
    assign m_connect_flag_bits = result_out.connect_flag_bits;
    assign m_keep_alive        = result_out.keep_alive;
    assign m_body_byte         = result_out.body_byte;
    assign m_body_valid        = result_out.body_valid;

endmodule
`default_nettype wire

/* sv/mfhp_in_stage.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfhp_in_stage
// Input register: holds one accepted beat until the parse step takes it.
// ----------------------------------------------------------------------------
module mfhp_in_stage (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire mfhp_pkg::item_t s_item,
    input  wire logic           advance,
    output logic                item_valid,
    output mfhp_pkg::item_t     item
);
    import mfhp_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    // Accept when empty or when the held beat moves on this cycle
    assign s_ready    = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    // Capture the payload of an accepted beat
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule
`default_nettype wire

/* sv/mfhp_step.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfhp_step
// Parse logic for one byte: next parser state and the result beat.
// ----------------------------------------------------------------------------
module mfhp_step #(
    parameter int MAX_LENGTH_BYTES = 4
) (
    input  wire mfhp_pkg::state_t state_i,
    input  wire mfhp_pkg::item_t  item,
    output mfhp_pkg::state_t      state_next,
    output mfhp_pkg::result_t     result
);
    import mfhp_pkg::*;

    localparam logic [2:0] MaxCnt = 3'(MAX_LENGTH_BYTES);

    state_t      eff;
    state_t      nxt;
    logic [7:0]  b;
    logic [27:0] len_term;
    logic [27:0] len_sum;
    logic [27:0] left_dec;
    logic [3:0]  name_len;
    logic [3:0]  idx_new;
    logic        hdr_ok;
    logic        hdr_complete;
    kind_t       kind_new;
    logic [7:0]  cap_level;
    logic [7:0]  cap_cflags;
    logic [15:0] cap_keep;
    err_t        ecode;
    logic        done;
    logic        body_ok;

    assign b = item.rx_byte;

    // Control byte rules per packet type
    function automatic logic ctrl_ok(input logic [3:0] t, input logic [3:0] f,
                                     input logic conn);
        logic ok;
        unique case (t)
            TYPE_RESERVED_LO, TYPE_RESERVED_HI: ok = 1'b0;
            TYPE_CONNECT:                       ok = conn && (f == FLAGS_ZERO);
            TYPE_PUBLISH:                       ok = 1'b1;
            TYPE_PUBREL, TYPE_SUBSCRIBE, TYPE_UNSUBSCRIBE:
                                                ok = (f == FLAGS_REQUIRED);
            default:                            ok = (f == FLAGS_ZERO);
        endcase
        return ok;
    endfunction

    // Apply restart before the byte is taken
    always_comb begin
        eff = state_i;
        if (item.restart) begin
            eff.phase      = PH_CTRL;
            eff.err        = ERR_NONE;
            eff.len_accum  = '0;
            eff.len_cnt    = '0;
            eff.bytes_left = '0;
            eff.hdr_idx    = '0;
            eff.name_kind  = KIND_NONE;
        end
    end

    // Place the 7-bit length group at its position
    always_comb begin
        unique case (eff.len_cnt[1:0])
            2'd0: len_term = {21'd0, b[6:0]};
            2'd1: len_term = {14'd0, b[6:0], 7'd0};
            2'd2: len_term = {7'd0, b[6:0], 14'd0};
            2'd3: len_term = {b[6:0], 21'd0};
        endcase
    end

    assign len_sum  = eff.len_accum + len_term;
    assign left_dec = (eff.bytes_left != '0) ? eff.bytes_left - 28'd1 : eff.bytes_left;

    // Check one CONNECT header byte at the current header index
    always_comb begin
        name_len   = (eff.name_kind == KIND_V4) ? NAME_LEN_V4[3:0] : NAME_LEN_V3[3:0];
        hdr_ok     = 1'b1;
        kind_new   = eff.name_kind;
        cap_level  = eff.level;
        cap_cflags = eff.cflags;
        cap_keep   = eff.keep_alive;
        priority if (eff.hdr_idx == 4'd0) begin
            hdr_ok = (b == 8'h00);
        end else if (eff.hdr_idx == 4'd1) begin
            priority if (b == NAME_LEN_V4) begin
                kind_new = KIND_V4;
            end else if (b == NAME_LEN_V3) begin
                kind_new = KIND_V3;
            end else begin
                hdr_ok = 1'b0;
            end
        end else if (eff.name_kind == KIND_NONE) begin
            hdr_ok = 1'b0;
        end else if (eff.hdr_idx < name_len + 4'd2) begin
            hdr_ok = (b == name_char(eff.name_kind, eff.hdr_idx - 4'd2));
        end else if (eff.hdr_idx == name_len + 4'd2) begin
            hdr_ok = (b == ((eff.name_kind == KIND_V4) ? LEVEL_V4 : LEVEL_V3));
            if (hdr_ok) begin
                cap_level = b;
            end
        end else if (eff.hdr_idx == name_len + 4'd3) begin
            cap_cflags = b;
        end else if (eff.hdr_idx == name_len + 4'd4) begin
            cap_keep = {b, 8'h00};
        end else if (eff.hdr_idx == name_len + 4'd5) begin
            cap_keep = {eff.keep_alive[15:8], b};
        end else begin
            hdr_ok = 1'b1;
        end
    end

    // Saturate the header index and see whether the header is complete
    assign idx_new = (eff.hdr_idx == HDR_IDX_MAX) ? eff.hdr_idx : eff.hdr_idx + 4'd1;
    assign hdr_complete = (kind_new != KIND_NONE) &&
        (idx_new >= ((kind_new == KIND_V4) ? NAME_LEN_V4[3:0] + 4'd6
                                           : NAME_LEN_V3[3:0] + 4'd6));

    // Advance the parser by one byte
    always_comb begin
        nxt     = eff;
        ecode   = ERR_NONE;
        done    = 1'b0;
        body_ok = 1'b0;
        unique case (eff.phase)
            PH_CTRL, PH_DONE: begin
                nxt.ptype = b[7:4];
                nxt.flags = b[3:0];
                if (ctrl_ok(b[7:4], b[3:0], item.session_connecting)) begin
                    nxt.phase      = PH_LEN;
                    nxt.len_accum  = '0;
                    nxt.len_cnt    = '0;
                    nxt.bytes_left = '0;
                    nxt.hdr_idx    = '0;
                    nxt.name_kind  = KIND_NONE;
                    if (b[7:4] == TYPE_CONNECT) begin
                        nxt.level      = '0;
                        nxt.cflags     = '0;
                        nxt.keep_alive = '0;
                    end
                end else begin
                    nxt.phase = PH_ERR;
                    nxt.err   = ERR_CTRL;
                    ecode     = ERR_CTRL;
                end
            end
            PH_LEN: begin
                if (eff.len_cnt >= MaxCnt) begin
                    nxt.phase = PH_ERR;
                    nxt.err   = ERR_LEN;
                    ecode     = ERR_LEN;
                end else begin
                    nxt.len_accum = len_sum;
                    nxt.len_cnt   = eff.len_cnt + 3'd1;
                    if (!b[7]) begin
                        nxt.bytes_left = len_sum;
                        priority if (len_sum != '0) begin
                            nxt.phase = PH_BODY;
                        end else if (eff.ptype == TYPE_CONNECT) begin
                            nxt.phase = PH_ERR;
                            nxt.err   = ERR_CONNECT;
                            ecode     = ERR_CONNECT;
                        end else begin
                            nxt.phase = PH_DONE;
                            done      = 1'b1;
                        end
                    end
                end
            end
            PH_BODY: begin
                body_ok        = 1'b1;
                nxt.bytes_left = left_dec;
                if (eff.ptype == TYPE_CONNECT) begin
                    nxt.hdr_idx    = idx_new;
                    nxt.name_kind  = kind_new;
                    nxt.level      = cap_level;
                    nxt.cflags     = cap_cflags;
                    nxt.keep_alive = cap_keep;
                    body_ok        = hdr_ok && !((left_dec == '0) && !hdr_complete);
                end
                if (!body_ok) begin
                    nxt.phase = PH_ERR;
                    nxt.err   = ERR_CONNECT;
                    ecode     = ERR_CONNECT;
                end else if (left_dec == '0) begin
                    nxt.phase = PH_DONE;
                    done      = 1'b1;
                end
            end
            default: begin
                // Hold the error and repeat its code until restart
                ecode = eff.err;
            end
        endcase
    end

    assign state_next = nxt;

    // Build the result beat
    always_comb begin
        result.error_code        = ecode;
        result.packet_done       = done;
        result.parse_phase       = nxt.phase;
        result.packet_type       = nxt.ptype;
        result.packet_flags      = nxt.flags;
        result.remaining_length  = nxt.len_accum;
        result.protocol_level    = nxt.level;
        result.connect_flag_bits = nxt.cflags;
        result.keep_alive        = nxt.keep_alive;
        result.body_byte         = body_ok ? b : 8'h00;
        result.body_valid        = body_ok;
    end

endmodule
`default_nettype wire

/* sv/mfhp_out_stage.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfhp_out_stage
// Result register: holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module mfhp_out_stage (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             load,
    input  wire mfhp_pkg::result_t result_in,
    output logic                  out_free,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output mfhp_pkg::result_t     result_out
);
    import mfhp_pkg::*;

    logic    valid_reg;
    result_t result_reg;

    // Free when empty or when the held beat leaves this cycle
    assign out_free   = !valid_reg || m_ready;
    assign m_valid    = valid_reg;
    assign result_out = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (out_free) begin
            valid_reg <= load;
        end
    end

    // Capture a new result beat
    always_ff @(posedge aclk) begin
        if (load && out_free) begin
            result_reg <= result_in;
        end
    end

endmodule
`default_nettype wire

/* sv/mfhp_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfhp_checker
// Port-level checks of the MQTT fixed-header parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "mqtt_fixed_header_parser_core_macros.svh"

module mfhp_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [1:0]  m_error_code,
    input wire logic        m_packet_done,
    input wire logic [2:0]  m_parse_phase,
    input wire logic [27:0] m_remaining_length,
    input wire logic [7:0]  m_body_byte,
    input wire logic        m_body_valid
);
    import mfhp_pkg::*;

    // Stalled result beat holds its value
    `MFHP_ASSERT(a_hold_stalled, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_error_code) && $stable(m_parse_phase) && $stable(m_body_byte) && $stable(m_remaining_length), "stalled result changed")

    // Packet completion only shows a clean completed phase
    `MFHP_ASSERT(a_done_phase, aclk, aresetn, m_valid && m_packet_done |-> m_parse_phase == PH_DONE && m_error_code == ERR_NONE, "packet_done outside completed phase")

    // Body bytes are passed only in body or completed phase without error
    `MFHP_ASSERT(a_body_phase, aclk, aresetn, m_valid && m_body_valid |-> (m_parse_phase == PH_BODY || m_parse_phase == PH_DONE) && m_error_code == ERR_NONE, "body byte outside body")

    // Error phase always carries a nonzero code
    `MFHP_ASSERT(a_err_code, aclk, aresetn, m_valid && m_parse_phase == PH_ERR |-> m_error_code != ERR_NONE, "error phase without code")

    // Reset leaves no result pending
    `MFHP_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind mqtt_fixed_header_parser_core mfhp_checker u_mfhp_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_error_code       (m_error_code),
    .m_packet_done      (m_packet_done),
    .m_parse_phase      (m_parse_phase),
    .m_remaining_length (m_remaining_length),
    .m_body_byte        (m_body_byte),
    .m_body_valid       (m_body_valid)
);
`default_nettype wire

/* test/tb_mqtt_fixed_header_parser_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mqtt_fixed_header_parser_core
// Self-checking bench for the MQTT fixed-header parser core.
// A directed set of packets covers the control-byte rules, the length limit,
// held errors, restart and the CONNECT header checks. Random packets follow,
// mostly well formed with random content, mixed with broken packets and
// noise. Each accepted byte runs through a local parser model, and each
// result beat is compared field by field in order. The sender works in
// bursts, and the receiver stalls on a changing pattern with long hold-offs.
// ----------------------------------------------------------------------------
module tb_mqtt_fixed_header_parser_core;
    import mfhp_pkg::*;

    localparam int          MAX_LEN      = 4;
    localparam int          RANDOM_BYTES = 2000;
    localparam int          LIMIT_CYCLES = 400000;
    localparam logic [3:0]  TYPE_PINGREQ = 4'd12;
    localparam logic [31:0] NAME_MQTT    = "MQTT";
    localparam logic [47:0] NAME_MQISDP  = "MQIsdp";

    typedef enum int {RX_OPEN, RX_COIN, RX_PATTERN, RX_SPARSE} rx_mode_t;

    logic        aclk                 = 1'b0;
    logic        aresetn              = 1'b0;
    logic        s_valid              = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte            = 8'h00;
    logic        s_session_connecting = 1'b0;
    logic        s_restart            = 1'b0;
    logic        m_valid;
    logic        m_ready              = 1'b0;
    logic [1:0]  m_error_code;
    logic        m_packet_done;
    logic [2:0]  m_parse_phase;
    logic [3:0]  m_packet_type;
    logic [3:0]  m_packet_flags;
    logic [27:0] m_remaining_length;
    logic [7:0]  m_protocol_level;
    logic [7:0]  m_connect_flag_bits;
    logic [15:0] m_keep_alive;
    logic [7:0]  m_body_byte;
    logic        m_body_valid;

    // Stimulus and expectations
    item_t   tx_bytes[$];
    result_t predicted_results[$];
    bit      stream_dirty = 1'b0;

    // Local parser model state
    phase_t      hdr_phase      = PH_CTRL;
    logic [3:0]  hdr_type       = '0;
    logic [3:0]  hdr_flags      = '0;
    logic [27:0] len_sum        = '0;
    logic [2:0]  len_count      = '0;
    logic [27:0] body_left      = '0;
    logic [3:0]  conn_idx       = '0;
    kind_t       conn_kind      = KIND_NONE;
    logic [7:0]  conn_level     = '0;
    logic [7:0]  conn_cflags    = '0;
    logic [15:0] conn_keepalive = '0;
    err_t        held_err       = ERR_NONE;

    // Handshake bookkeeping
    bit       s_took      = 1'b0;
    int       burst_left  = 0;
    int       gap_left    = 0;
    int       hold_left   = 0;
    int       holds_done  = 0;
    int       ready_cycle = 0;
    rx_mode_t ready_mode  = RX_OPEN;
    int       beats_in    = 0;
    int       results_in  = 0;
    int       mismatches  = 0;
    int       cycles      = 0;

    mqtt_fixed_header_parser_core #(.MAX_LENGTH_BYTES(MAX_LEN)) DUT (.*);

    initial begin
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------

    // Check one CONNECT variable-header byte and capture its fields
    function automatic bit check_connect_byte(input logic [7:0] b);
        int unsigned i;
        int unsigned n;
        int unsigned k;
        i = conn_idx;
        n = (conn_kind == KIND_V4) ? 4 : 6;
        if (i == 0) return b == 8'h00;
        if (i == 1) begin
            if (b == NAME_LEN_V4) begin
                conn_kind = KIND_V4;
                return 1'b1;
            end
            if (b == NAME_LEN_V3) begin
                conn_kind = KIND_V3;
                return 1'b1;
            end
            return 1'b0;
        end
        if (conn_kind == KIND_NONE) return 1'b0;
        if (i < n + 2) begin
            k = i - 2;
            if (conn_kind == KIND_V4) return b == NAME_MQTT[31 - 8 * k -: 8];
            return b == NAME_MQISDP[47 - 8 * k -: 8];
        end
        if (i == n + 2) begin
            if (b != ((conn_kind == KIND_V4) ? LEVEL_V4 : LEVEL_V3)) return 1'b0;
            conn_level = b;
            return 1'b1;
        end
        if (i == n + 3) conn_cflags = b;
        if (i == n + 4) conn_keepalive = {b, 8'h00};
        if (i == n + 5) conn_keepalive[7:0] = b;
        return 1'b1;
    endfunction

    // Advance the parser by one byte and return the result it produces
    function automatic result_t parse_rx_byte(input item_t it);
        result_t     r;
        logic [7:0]  b;
        bit          legal;
        bit          ok;
        bit          done;
        bit          valid;
        r     = '0;
        b     = it.rx_byte;
        done  = 1'b0;
        valid = 1'b0;

        // Restart drops any packet in progress and any held error
        if (it.restart) begin
            hdr_phase = PH_CTRL;
            held_err  = ERR_NONE;
            len_sum   = '0;
            len_count = '0;
            body_left = '0;
            conn_idx  = '0;
            conn_kind = KIND_NONE;
        end
        r.error_code = ERR_NONE;

        case (hdr_phase)
            PH_CTRL, PH_DONE: begin
                hdr_type  = b[7:4];
                hdr_flags = b[3:0];
                case (hdr_type)
                    TYPE_RESERVED_LO, TYPE_RESERVED_HI: legal = 1'b0;
                    TYPE_CONNECT: legal = it.session_connecting && hdr_flags == FLAGS_ZERO;
                    TYPE_PUBLISH: legal = 1'b1;
                    TYPE_PUBREL, TYPE_SUBSCRIBE, TYPE_UNSUBSCRIBE:
                        legal = hdr_flags == FLAGS_REQUIRED;
                    default: legal = hdr_flags == FLAGS_ZERO;
                endcase
                if (legal) begin
                    hdr_phase = PH_LEN;
                    len_sum   = '0;
                    len_count = '0;
                    body_left = '0;
                    conn_idx  = '0;
                    conn_kind = KIND_NONE;
                    if (hdr_type == TYPE_CONNECT) begin
                        conn_level     = '0;
                        conn_cflags    = '0;
                        conn_keepalive = '0;
                    end
                end else begin
                    held_err     = ERR_CTRL;
                    hdr_phase    = PH_ERR;
                    r.error_code = ERR_CTRL;
                end
            end
            PH_LEN: begin
                if (len_count >= MAX_LEN || len_count >= 4) begin
                    held_err     = ERR_LEN;
                    hdr_phase    = PH_ERR;
                    r.error_code = ERR_LEN;
                end else begin
                    len_sum   = len_sum + ({21'd0, b[6:0]} << (7 * len_count));
                    len_count = len_count + 3'd1;
                    if (!b[7]) begin
                        body_left = len_sum;
                        if (body_left != 0) begin
                            hdr_phase = PH_BODY;
                        end else if (hdr_type == TYPE_CONNECT) begin
                            held_err     = ERR_CONNECT;
                            hdr_phase    = PH_ERR;
                            r.error_code = ERR_CONNECT;
                        end else begin
                            hdr_phase = PH_DONE;
                            done      = 1'b1;
                        end
                    end
                end
            end
            PH_BODY: begin
                ok = 1'b1;
                if (hdr_type == TYPE_CONNECT) begin
                    ok = check_connect_byte(b);
                    if (conn_idx < HDR_IDX_MAX) conn_idx = conn_idx + 4'd1;
                end
                if (body_left != 0) body_left = body_left - 28'd1;
                // A CONNECT body may not end before the keep-alive is in
                if (ok && body_left == 0 && hdr_type == TYPE_CONNECT &&
                    !(conn_kind != KIND_NONE &&
                      conn_idx >= ((conn_kind == KIND_V4) ? 4'd10 : 4'd12))) begin
                    ok = 1'b0;
                end
                if (!ok) begin
                    held_err     = ERR_CONNECT;
                    hdr_phase    = PH_ERR;
                    r.error_code = ERR_CONNECT;
                end else begin
                    valid = 1'b1;
                    if (body_left == 0) begin
                        hdr_phase = PH_DONE;
                        done      = 1'b1;
                    end
                end
            end
            default: r.error_code = held_err;
        endcase

        r.packet_done       = done;
        r.parse_phase       = hdr_phase;
        r.packet_type       = hdr_type;
        r.packet_flags      = hdr_flags;
        r.remaining_length  = len_sum;
        r.protocol_level    = conn_level;
        r.connect_flag_bits = conn_cflags;
        r.keep_alive        = conn_keepalive;
        r.body_byte         = valid ? b : 8'h00;
        r.body_valid        = valid;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------

    task automatic queue_byte(input logic [7:0] b, input logic conn, input logic rst);
        item_t it;
        it.rx_byte            = b;
        it.session_connecting = conn;
        it.restart            = rst;
        tx_bytes.push_back(it);
    endtask

    // Encode a remaining length, optionally padded with extra continuation groups
    task automatic queue_length(input logic [27:0] value, input bit pad);
        int nb;
        nb = 1;
        while (nb < 4 && (value >> (7 * nb)) != 0) nb++;
        if (pad) nb = $urandom_range(nb, 4);
        for (int i = 0; i < nb; i++) begin
            queue_byte({(i < nb - 1) ? 1'b1 : 1'b0, 7'((value >> (7 * i)) & 28'h7F)},
                       1'($urandom_range(0, 1)), 1'b0);
        end
    endtask

    // CONNECT packet, clean or with one flaw
    task automatic queue_connect_packet();
        logic [7:0]  body[$];
        logic [3:0]  flags;
        bit          v3;
        bit          conn;
        int unsigned flaw;
        int unsigned len;
        int unsigned pos;
        v3 = ($urandom_range(0, 2) == 0);
        body.push_back(8'h00);
        if (v3) begin
            body.push_back(NAME_LEN_V3);
            for (int k = 0; k < 6; k++) body.push_back(NAME_MQISDP[47 - 8 * k -: 8]);
            body.push_back(LEVEL_V3);
        end else begin
            body.push_back(NAME_LEN_V4);
            for (int k = 0; k < 4; k++) body.push_back(NAME_MQTT[31 - 8 * k -: 8]);
            body.push_back(LEVEL_V4);
        end
        repeat (3) body.push_back(8'($urandom));
        repeat ($urandom_range(0, 6)) body.push_back(8'($urandom));

        // Flaws: 0 corrupt header byte, 1 short body, 2 zero length,
        // 3 not connecting, 4 nonzero flags; the rest are clean
        flaw  = $urandom_range(0, 9);
        len   = body.size();
        flags = FLAGS_ZERO;
        conn  = 1'b1;
        case (flaw)
            0: begin
                pos = $urandom_range(0, v3 ? 8 : 6);
                body[pos] = body[pos] ^ 8'($urandom_range(1, 255));
            end
            1: len = $urandom_range(1, v3 ? 11 : 9);
            2: len = 0;
            3: conn = 1'b0;
            4: flags = 4'($urandom_range(1, 15));
            default: ;
        endcase

        queue_byte({TYPE_CONNECT, flags}, conn, stream_dirty || $urandom_range(0, 7) == 0);
        queue_length(28'(len), $urandom_range(0, 5) == 0);
        for (int i = 0; i < len; i++) queue_byte(body[i], 1'($urandom_range(0, 1)), 1'b0);
        stream_dirty = (flaw < 5);
    endtask

    // Any other packet type, clean or with one flaw
    task automatic queue_plain_packet();
        logic [3:0]  t;
        logic [3:0]  f;
        logic [27:0] len;
        int unsigned flaw;
        t = 4'($urandom_range(2, 14));
        if (t == TYPE_PUBLISH) f = 4'($urandom);
        else if (t == TYPE_PUBREL || t == TYPE_SUBSCRIBE || t == TYPE_UNSUBSCRIBE)
            f = FLAGS_REQUIRED;
        else f = FLAGS_ZERO;

        // Flaws: 0 bad flags, 1 reserved type, 2 five length bytes,
        // 3 huge length cut short by the next restart
        flaw = $urandom_range(0, 19);
        if (flaw == 0 && t != TYPE_PUBLISH) f = f ^ 4'($urandom_range(1, 15));
        if (flaw == 1) begin
            t = $urandom_range(0, 1) ? TYPE_RESERVED_HI : TYPE_RESERVED_LO;
            f = 4'($urandom);
        end

        queue_byte({t, f}, 1'($urandom_range(0, 1)), stream_dirty || $urandom_range(0, 7) == 0);
        if (flaw == 2) begin
            repeat (4) queue_byte({1'b1, 7'($urandom)}, 1'b0, 1'b0);
            queue_byte(8'($urandom), 1'b0, 1'b0);
        end else if (flaw == 3) begin
            queue_length(28'($urandom), 1'b0);
            repeat ($urandom_range(0, 4)) queue_byte(8'($urandom), 1'b0, 1'b0);
        end else begin
            len = ($urandom_range(0, 7) == 0) ? 28'($urandom_range(0, 200))
                                              : 28'($urandom_range(0, 16));
            queue_length(len, $urandom_range(0, 5) == 0);
            repeat (len) queue_byte(8'($urandom), 1'($urandom_range(0, 1)), 1'b0);
        end
        stream_dirty = (flaw < 4);
    endtask

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial begin : stimulus
        int directed_n;

        // Clean CONNECT, level 4, all flag and keep-alive bits set
        queue_byte({TYPE_CONNECT, FLAGS_ZERO}, 1'b1, 1'b1);
        queue_byte(8'd10, 1'b0, 1'b0);
        queue_byte(8'h00, 1'b0, 1'b0);
        queue_byte(NAME_LEN_V4, 1'b0, 1'b0);
        for (int k = 0; k < 4; k++) queue_byte(NAME_MQTT[31 - 8 * k -: 8], 1'b0, 1'b0);
        queue_byte(LEVEL_V4, 1'b0, 1'b0);
        repeat (3) queue_byte(8'hFF, 1'b0, 1'b0);
        // Zero remaining length completes on the length byte
        queue_byte({TYPE_PINGREQ, FLAGS_ZERO}, 1'b0, 1'b0);
        queue_byte(8'h00, 1'b0, 1'b0);
        // CONNECT outside connecting, then a byte while the error is held
        queue_byte({TYPE_CONNECT, FLAGS_ZERO}, 1'b0, 1'b0);
        queue_byte(8'hFF, 1'b1, 1'b0);
        // Both reserved types
        queue_byte({TYPE_RESERVED_LO, FLAGS_ZERO}, 1'b1, 1'b1);
        queue_byte({TYPE_RESERVED_HI, 4'hF}, 1'b1, 1'b1);
        // PUBLISH with all flags, then one length byte too many
        queue_byte({TYPE_PUBLISH, 4'hF}, 1'b0, 1'b1);
        repeat (4) queue_byte(8'hFF, 1'b0, 1'b0);
        queue_byte(8'h7F, 1'b0, 1'b0);
        // CONNECT with zero remaining length
        queue_byte({TYPE_CONNECT, FLAGS_ZERO}, 1'b1, 1'b1);
        queue_byte(8'h00, 1'b0, 1'b0);
        stream_dirty = 1'b1;

        // Random packets, mostly well formed, some broken, some noise
        directed_n = tx_bytes.size();
        while (tx_bytes.size() < directed_n + RANDOM_BYTES) begin
            case ($urandom_range(0, 9))
                0: begin
                    repeat ($urandom_range(1, 6)) begin
                        queue_byte(8'($urandom), 1'($urandom_range(0, 1)),
                                   $urandom_range(0, 3) == 0);
                    end
                    stream_dirty = 1'b1;
                end
                1, 2, 3: queue_connect_packet();
                default: queue_plain_packet();
            endcase
        end

        // Hold reset, then release it on a falling edge
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Drain, then allow the pipeline latency
        do @(posedge aclk);
        while (tx_bytes.size() != 0 || s_valid || predicted_results.size() != 0);
        repeat (8) @(posedge aclk);

        if (mismatches == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sender: bursts of beats with random gaps
    // ------------------------------------------------------------------
    always @(negedge aclk) begin : drive_bytes
        item_t nxt;
        if (aresetn && (!s_valid || s_took)) begin
            if (gap_left != 0 || tx_bytes.size() == 0) begin
                if (gap_left != 0) gap_left--;
                s_valid <= 1'b0;
            end else begin
                nxt = tx_bytes.pop_front();
                s_valid              <= 1'b1;
                s_rx_byte            <= nxt.rx_byte;
                s_session_connecting <= nxt.session_connecting;
                s_restart            <= nxt.restart;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: changing stall pattern plus two long hold-offs
    // ------------------------------------------------------------------
    always @(negedge aclk) begin : drive_ready
        if (aresetn) begin
            ready_cycle++;
            if (ready_cycle % 64 == 0) ready_mode = rx_mode_t'($urandom_range(0, 3));
            if (hold_left == 0 && ((holds_done == 0 && beats_in >= 400) ||
                                   (holds_done == 1 && beats_in >= 1500))) begin
                hold_left = 300;
                holds_done++;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (ready_mode)
                    RX_OPEN:    m_ready <= 1'b1;
                    RX_COIN:    m_ready <= 1'($urandom_range(0, 1));
                    RX_PATTERN: m_ready <= (ready_cycle % 5) >= 2;
                    default:    m_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Scoreboard: predict on input beats, compare on result beats
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [27:0] want,
                               input logic [27:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch in %0s at result %0d: expected 0x%0h, actual 0x%0h",
                         name, results_in, want, got);
            end
        end
    endtask

    always @(posedge aclk) begin : score
        item_t   it;
        result_t want;
        s_took = aresetn && s_valid && s_ready;
        if (s_took) begin
            it.rx_byte            = s_rx_byte;
            it.session_connecting = s_session_connecting;
            it.restart            = s_restart;
            predicted_results.push_back(parse_rx_byte(it));
            beats_in++;
        end
        if (aresetn && m_valid && m_ready) begin
            results_in++;
            if (predicted_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("result beat %0d with none expected", results_in);
            end else begin
                want = predicted_results.pop_front();
                check_field("error_code", want.error_code, m_error_code);
                check_field("packet_done", want.packet_done, m_packet_done);
                check_field("parse_phase", want.parse_phase, m_parse_phase);
                check_field("packet_type", want.packet_type, m_packet_type);
                check_field("packet_flags", want.packet_flags, m_packet_flags);
                check_field("remaining_length", want.remaining_length, m_remaining_length);
                check_field("protocol_level", want.protocol_level, m_protocol_level);
                check_field("connect_flag_bits", want.connect_flag_bits,
                            m_connect_flag_bits);
                check_field("keep_alive", want.keep_alive, m_keep_alive);
                check_field("body_byte", want.body_byte, m_body_byte);
                check_field("body_valid", want.body_valid, m_body_valid);
            end
        end
    end

    // Stop a hung run
    always @(posedge aclk) begin : watchdog
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

endmodule
